/* design/mma_pkg.sv */
`timescale 1ns / 1ps
package mma_pkg;

    // One input beat: opcode, raw PRNG word and the index for a read.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] sample_word;
        logic [11:0] read_index;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic        accepted;
        logic [11:0] entry_index;
        logic        pass_done;
        logic [62:0] entry_value;
    } t_result;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_READ,
        OP_CLEAR
    } t_opcode;

    typedef enum logic [1:0] {
        REG_MODULUS,
        REG_KEEP_BITS,
        REG_REJECT_BELOW,
        REG_VECTOR_LENGTH
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_READ_OUT,
        ST_PREP,
        ST_DIV_S,
        ST_DIV_V,
        ST_SUM,
        ST_WB
    } t_state;

    // Request to the remainder unit.
    typedef struct packed {
        logic        start;
        logic [5:0]  nbits;
        logic [62:0] dividend;
    } t_div_req;

    // Memory port strobes.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    localparam logic [63:0] MOD_MIN   = 64'd2;
    localparam logic [63:0] MOD_MAX   = 64'h8000_0000_0000_0000;
    localparam logic [5:0]  FULL_BITS = 6'd63;

endpackage

/* design/mma_store.sv */
`timescale 1ns / 1ps
module mma_store #(
    parameter int MAX_LENGTH = 4096,
    parameter int AW         = 12
) (
    input  logic               i_clk,
    input  mma_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic [62:0]        i_wdata,
    output logic [62:0]        o_rdata
);
    import mma_pkg::*;

    logic [62:0] r_mem [MAX_LENGTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read data registered; holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

/* design/mma_rem.sv */
`timescale 1ns / 1ps
module mma_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mma_pkg::t_div_req i_req,
    input  logic [63:0]       i_modulus,
    output logic              o_done,
    output logic [63:0]       o_rem
);
    import mma_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [62:0] r_dvd;
    logic [63:0] r_rem;
    logic [5:0]  bit_idx;
    logic [63:0] shifted;
    logic [63:0] rem_step;

    // One dividend bit per cycle, most significant first.
    assign bit_idx  = r_cnt - 6'd1;
    assign shifted  = {r_rem[62:0], r_dvd[bit_idx]};
    assign rem_step = (shifted >= i_modulus) ? (shifted - i_modulus) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= bit_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
        end else if (r_busy && (r_cnt != 6'd0)) begin
            r_rem <= rem_step;
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd0);
    assign o_rem  = r_rem;

endmodule

/* design/modular_mask_accumulator_top.sv */
`timescale 1ns / 1ps
// Modular mask accumulator.
// Command channel: drive i_item and raise start; the beat is taken at an edge
// where start is high and busy is low. Opcodes: add sample, subtract sample,
// read entry, clear store and position.
// Result channel: every command gives exactly one result beat, shown on
// o_result for one cycle with o_res_strobe high. The receiver cannot stall,
// so it must take the beat in that cycle.
// An accepted sample waits on the remainder unit for the kept bits, and
// for all 63 bits again when the stored entry is not below the modulus
// (modulus changed mid-pass); a clear sweeps all MAX_LENGTH entries. The
// remainder unit retires one dividend bit per cycle, and that sets the rate;
// one command is in flight at a time.
// Reset: the mask store is swept to zero, one entry per cycle, with busy
// high; configuration writes are taken meanwhile.
// Configuration is an APB slave with 64-bit data, registers at 8-byte
// spacing; write it only while busy is low.
module modular_mask_accumulator_top #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mma_pkg::t_item   i_item,
    output logic             o_res_strobe,
    output mma_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import mma_pkg::*;

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);
    localparam logic [31:0]   MAX_LEN32 = 32'(MAX_LENGTH);

    // Configuration registers
    logic [63:0] r_modulus;
    logic [5:0]  r_keep_bits;
    logic [62:0] r_reject_below;
    logic [12:0] r_vector_length;

    // Control and datapath registers
    t_state        r_state, n_state;
    t_item         r_item, n_item;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pos, n_pos;
    logic [63:0]   r_r, n_r;
    logic [62:0]   r_v, n_v;
    logic [63:0]   r_s, n_s;
    logic          r_res_vld, n_res_vld;
    t_result       r_res, n_res;

    // Memory and remainder unit hookup
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [62:0]   mem_wdata;
    logic [62:0]   mem_rdata;
    t_div_req      div_req;
    logic          div_done;
    logic [63:0]   div_rem;

    // Derived values
    logic [63:0]   m_eff;
    logic [31:0]   len_eff;
    logic [31:0]   pos_ext;
    logic [AW-1:0] pos_eff;
    logic [31:0]   pos_eff_ext;
    logic [62:0]   keep;
    logic [62:0]   sample;
    logic [31:0]   rd_idx_ext;
    logic          rd_ok;
    logic [63:0]   v_new;
    logic          last;
    logic          cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus       <= MOD_MIN;
            r_keep_bits     <= 6'd1;
            r_reject_below  <= '0;
            r_vector_length <= 13'd1;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_MODULUS:       r_modulus       <= pwdata;
                REG_KEEP_BITS:     r_keep_bits     <= pwdata[5:0];
                REG_REJECT_BELOW:  r_reject_below  <= pwdata[62:0];
                REG_VECTOR_LENGTH: r_vector_length <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_MODULUS:       prdata = r_modulus;
            REG_KEEP_BITS:     prdata = {58'd0, r_keep_bits};
            REG_REJECT_BELOW:  prdata = {1'b0, r_reject_below};
            REG_VECTOR_LENGTH: prdata = {51'd0, r_vector_length};
            default:           prdata = '0;
        endcase
    end

    // ---------------- clamped settings ----------------
    // Clamp the modulus to 2 .. 2^63 and the length to 1 .. MAX_LENGTH.
    always_comb begin
        if (r_modulus < MOD_MIN) begin
            m_eff = MOD_MIN;
        end else if (r_modulus > MOD_MAX) begin
            m_eff = MOD_MAX;
        end else begin
            m_eff = r_modulus;
        end
        len_eff = {19'd0, r_vector_length};
        if (len_eff == 32'd0) begin
            len_eff = 32'd1;
        end else if (len_eff > MAX_LEN32) begin
            len_eff = MAX_LEN32;
        end
    end

    // A position left past a lowered length restarts at zero.
    assign pos_ext     = 32'(r_pos);
    assign pos_eff     = (pos_ext >= len_eff) ? '0 : r_pos;
    assign pos_eff_ext = 32'(pos_eff);

    assign keep   = ~({63{1'b1}} << r_keep_bits);
    assign sample = r_item.sample_word[62:0] & keep;

    assign rd_idx_ext = 32'(r_item.read_index);
    assign rd_ok      = rd_idx_ext < MAX_LEN32;

    assign v_new = (r_s >= m_eff) ? (r_s - m_eff) : r_s;
    assign last  = (pos_ext + 32'd1) >= len_eff;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_r    <= n_r;
        r_v    <= n_v;
        r_s    <= n_s;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_r       = r_r;
        n_v       = r_v;
        n_s       = r_s;
        n_res_vld = 1'b0;
        n_res     = r_res;
        mem_ctl   = '0;
        mem_addr  = r_pos;
        mem_wdata = '0;
        div_req   = '0;

        unique case (r_state)
            // Sweep zeros through the store, one entry per cycle.
            ST_INIT, ST_CLEAR: begin
                mem_ctl.we = 1'b1;
                mem_addr   = r_cnt;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                    if (r_state == ST_CLEAR) begin
                        n_pos     = '0;
                        n_res_vld = 1'b1;
                        n_res     = '0;
                    end
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    unique case (t_opcode'(i_item.opcode))
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_READ: n_state = ST_READ;
                        default: n_state = ST_PREP;
                    endcase
                end
            end
            ST_READ: begin
                mem_ctl.re = rd_ok;
                mem_addr   = rd_idx_ext[AW-1:0];
                n_state    = ST_READ_OUT;
            end
            ST_READ_OUT: begin
                n_res_vld         = 1'b1;
                n_res.accepted    = 1'b0;
                n_res.pass_done   = 1'b0;
                n_res.entry_index = r_item.read_index;
                n_res.entry_value = rd_ok ? mem_rdata : '0;
                n_state           = ST_IDLE;
            end
            // Fix the position, test rejection, start the sample remainder
            // and fetch the entry in parallel.
            ST_PREP: begin
                n_pos = pos_eff;
                if (sample < r_reject_below) begin
                    n_res_vld         = 1'b1;
                    n_res.accepted    = 1'b0;
                    n_res.pass_done   = 1'b0;
                    n_res.entry_index = pos_eff_ext[11:0];
                    n_res.entry_value = '0;
                    n_state           = ST_IDLE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.nbits    = r_keep_bits;
                    div_req.dividend = sample;
                    mem_ctl.re       = 1'b1;
                    mem_addr         = pos_eff;
                    n_state          = ST_DIV_S;
                end
            end
            // Subtract becomes add of (m - r); a stale entry is reduced first.
            ST_DIV_S: begin
                if (div_done) begin
                    n_r = (t_opcode'(r_item.opcode) == OP_SUB) ? (m_eff - div_rem) : div_rem;
                    n_v = mem_rdata;
                    if ({1'b0, mem_rdata} >= m_eff) begin
                        div_req.start    = 1'b1;
                        div_req.nbits    = FULL_BITS;
                        div_req.dividend = mem_rdata;
                        n_state          = ST_DIV_V;
                    end else begin
                        n_state = ST_SUM;
                    end
                end
            end
            ST_DIV_V: begin
                if (div_done) begin
                    n_v     = div_rem[62:0];
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_s     = {1'b0, r_v} + r_r;
                n_state = ST_WB;
            end
            // Reduce once, write back, report and advance the position.
            ST_WB: begin
                mem_ctl.we        = 1'b1;
                mem_addr          = r_pos;
                mem_wdata         = v_new[62:0];
                n_res_vld         = 1'b1;
                n_res.accepted    = 1'b1;
                n_res.pass_done   = last;
                n_res.entry_index = pos_ext[11:0];
                n_res.entry_value = v_new[62:0];
                n_pos             = last ? '0 : (r_pos + 1'b1);
                n_state           = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_res_strobe = r_res_vld;
    assign o_result     = r_res;

    mma_store #(
        .MAX_LENGTH (MAX_LENGTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    mma_rem u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_modulus (m_eff),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

endmodule

/* design/mma_checker.sv */
`timescale 1ns / 1ps
module mma_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_res_strobe,
    input mma_pkg::t_result o_result
);
    import mma_pkg::*;

    // Reset starts the store sweep, so the block reports busy.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A taken command keeps the block busy until its result.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after a command beat");

    // One command at a time: result beats never come back to back.
    a_no_double_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("two result beats in a row");

    // A pass can end only on a sample that updated an entry.
    a_pass_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.pass_done) |-> o_result.accepted)
        else $error("pass_done without accepted");

endmodule

bind modular_mask_accumulator_top mma_checker u_mma_checker (.*);

/* verif/tb_modular_mask_accumulator_top.sv */
`timescale 1ns / 1ps
module tb_modular_mask_accumulator_top;
    import mma_pkg::*;

    localparam int          MAX_LEN     = 4096;
    localparam int          CYCLE_LIMIT = 1_200_000;
    // Covers the longest accepted sample: 63 kept bits, plus a full reduction of a stale entry.
    localparam int          DRAIN_WAIT  = 160;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_res_strobe;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    modular_mask_accumulator_top #(.MAX_LENGTH(MAX_LEN)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_strobe(o_res_strobe),
        .o_result    (o_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: configuration, mask store and position.
    // ------------------------------------------------------------------
    logic [63:0]  cfg_modulus;
    logic [5:0]   cfg_bits;
    logic [62:0]  cfg_reject;
    logic [12:0]  cfg_length;
    logic [62:0]  shadow_store [0:MAX_LEN-1];
    int unsigned  shadow_pos;

    t_result      expected_results [$];
    int           error_count = 0;
    int           sender_idle_pct;
    int unsigned  cycle_count = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_modular_mask_accumulator_top: errors");
            $finish;
        end
    end

    function automatic logic [63:0] clamp_modulus();
        if (cfg_modulus < MOD_MIN) return MOD_MIN;
        if (cfg_modulus > MOD_MAX) return MOD_MAX;
        return cfg_modulus;
    endfunction

    function automatic int unsigned clamp_length();
        if (cfg_length == 13'd0) return 1;
        if (cfg_length > MAX_LEN) return MAX_LEN;
        return 32'(cfg_length);
    endfunction

    // Work out the result of one accepted beat and advance the shadow state.
    function automatic t_result predict_mask_update(input t_item beat);
        t_result     res;
        logic [63:0] m;
        logic [63:0] keep;
        logic [63:0] smp;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] s;
        int unsigned len;
        res = '0;
        case (beat.opcode)
            OP_CLEAR: begin
                for (int i = 0; i < MAX_LEN; i++) shadow_store[i] = '0;
                shadow_pos = 0;
            end
            OP_READ: begin
                res.entry_index = beat.read_index;
                res.entry_value = shadow_store[beat.read_index];
            end
            default: begin
                m    = clamp_modulus();
                len  = clamp_length();
                keep = (cfg_bits == 6'd0) ? 64'd0 : ((64'd1 << cfg_bits) - 64'd1);
                smp  = beat.sample_word & keep;
                // A position left beyond a lowered length restarts the pass.
                if (shadow_pos >= len) shadow_pos = 0;
                res.entry_index = 12'(shadow_pos);
                if (smp >= {1'b0, cfg_reject}) begin
                    r = smp % m;
                    // Reduce a stale entry left from an earlier modulus.
                    v = {1'b0, shadow_store[shadow_pos]} % m;
                    if (beat.opcode == OP_ADD) begin
                        s = v + r;
                        v = (s >= m) ? s - m : s;
                    end else begin
                        v = (v >= r) ? v - r : v + (m - r);
                    end
                    shadow_store[shadow_pos] = v[62:0];
                    res.accepted    = 1'b1;
                    res.entry_value = v[62:0];
                    if (shadow_pos + 1 >= len) begin
                        res.pass_done = 1'b1;
                        shadow_pos    = 0;
                    end else begin
                        shadow_pos++;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_item make_beat(input t_opcode op, input logic [63:0] word,
                                        input logic [11:0] idx);
        t_item beat;
        beat.opcode      = op;
        beat.sample_word = word;
        beat.read_index  = idx;
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // Present one command beat, hold it until taken, then maybe idle.
    task automatic send_beat(input t_item beat);
        t_item junk;
        start  = 1'b1;
        i_item = beat;
        do @(posedge clk); while (busy !== 1'b0);
        expected_results.push_back(predict_mask_update(beat));
        @(negedge clk);
        if (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            // Drop start and put junk on the bus; the block must ignore it.
            junk.opcode      = 2'($urandom);
            junk.sample_word = {$urandom, $urandom};
            junk.read_index  = 12'($urandom);
            start  = 1'b0;
            i_item = junk;
            if ($urandom_range(4, 0) == 0)
                repeat ($urandom_range(140, 5)) @(negedge clk);
            else
                repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    // Lower start and wait until every result is in and the block is idle.
    task automatic wait_idle();
        start = 1'b0;
        while (expected_results.size() != 0 || busy !== 1'b0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // APB write: setup cycle, access cycle, hold until pready.
    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_MODULUS:       cfg_modulus = value;
            REG_KEEP_BITS:     cfg_bits    = value[5:0];
            REG_REJECT_BELOW:  cfg_reject  = value[62:0];
            REG_VECTOR_LENGTH: cfg_length  = value[12:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_config(input logic [63:0] m, input logic [63:0] bits,
                                input logic [63:0] thr, input logic [63:0] len);
        wait_idle();
        cfg_write(REG_MODULUS, m);
        cfg_write(REG_KEEP_BITS, bits);
        cfg_write(REG_REJECT_BELOW, thr);
        cfg_write(REG_VECTOR_LENGTH, len);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every strobed beat with the oldest prediction.
    // ------------------------------------------------------------------
    task automatic report_field(input string field, input logic [63:0] exp_v,
                                input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            error_count++;
            $display("%0t mismatch %s: expected %h actual %h", $time, field, exp_v, got_v);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n === 1'b1 && o_res_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t unexpected result: expected none actual %h", $time, o_result);
            end else begin
                want = expected_results.pop_front();
                report_field("accepted", 64'(want.accepted), 64'(o_result.accepted));
                report_field("entry_index", 64'(want.entry_index),
                             64'(o_result.entry_index));
                report_field("pass_done", 64'(want.pass_done), 64'(o_result.pass_done));
                report_field("entry_value", 64'(want.entry_value),
                             64'(o_result.entry_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Power-on registers: modulus 2, one sample bit, no rejection, length 1.
    task automatic test_power_on_defaults();
        send_beat(make_beat(OP_READ, '0, 12'd0));
        send_beat(make_beat(OP_ADD, ALL_ONES, 12'd0));
        send_beat(make_beat(OP_SUB, 64'd1, 12'd0));
        send_beat(make_beat(OP_READ, '0, 12'hFFF));
    endtask

    // Largest modulus and full 63-bit samples: sums near the top of the range.
    task automatic test_full_width();
        write_config(MOD_MAX, 64'd63, 64'd0, 64'd3);
        send_beat(make_beat(OP_ADD, ALL_ONES, 12'd0));
        send_beat(make_beat(OP_SUB, 64'd1, 12'd0));
        send_beat(make_beat(OP_ADD, 64'd0, 12'd0));
        send_beat(make_beat(OP_ADD, ALL_ONES, 12'd0));
        send_beat(make_beat(OP_READ, '0, 12'd1));
    endtask

    // Samples below the threshold leave the store alone; high word bits are dropped.
    task automatic test_rejection();
        write_config(64'd3, 64'd2, 64'd1, 64'd4);
        send_beat(make_beat(OP_ADD, 64'd0, 12'd0));
        send_beat(make_beat(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFC, 12'd0));
        send_beat(make_beat(OP_ADD, 64'd3, 12'd0));
        send_beat(make_beat(OP_SUB, 64'd2, 12'd0));
        // Highest threshold: only the all-ones sample gets through.
        write_config(MOD_MAX, 64'd63, ALL_ONES, 64'd2);
        send_beat(make_beat(OP_ADD, ALL_ONES - 64'd1, 12'd0));
        send_beat(make_beat(OP_ADD, ALL_ONES, 12'd0));
    endtask

    // Out-of-range registers get clamped; zero sample bits keep nothing.
    task automatic test_register_clamps();
        write_config(64'd0, 64'd4, 64'd0, 64'd0);
        send_beat(make_beat(OP_ADD, 64'd7, 12'd0));
        write_config(64'd1, 64'd0, 64'd0, 64'd8191);
        send_beat(make_beat(OP_SUB, ALL_ONES, 12'd0));
        write_config(ALL_ONES, 64'd62, 64'd0, 64'd4097);
        send_beat(make_beat(OP_ADD, ALL_ONES, 12'd0));
    endtask

    // Lower the length mid-pass, then shrink the modulus under stored entries.
    task automatic test_shrink_and_stale();
        write_config(64'd1000, 64'd16, 64'd0, 64'd6);
        send_beat(make_beat(OP_CLEAR, '0, 12'd0));
        for (int i = 0; i < 4; i++)
            send_beat(make_beat(OP_ADD, {$urandom, $urandom}, 12'd0));
        write_config(64'd1000, 64'd16, 64'd0, 64'd2);
        send_beat(make_beat(OP_ADD, 64'd999, 12'd0));
        write_config(64'd7, 64'd16, 64'd0, 64'd2);
        send_beat(make_beat(OP_ADD, 64'd5, 12'd0));
        send_beat(make_beat(OP_SUB, 64'd6, 12'd0));
        send_beat(make_beat(OP_CLEAR, '0, 12'd0));
        send_beat(make_beat(OP_READ, '0, 12'd1));
    endtask

    // ------------------------------------------------------------------
    // Random traffic.
    // ------------------------------------------------------------------

    // Pick a register set; the threshold mostly follows the unbiased-sampling rule.
    task automatic randomize_config();
        logic [63:0] m;
        logic [63:0] m_eff;
        logic [63:0] span;
        logic [63:0] bits;
        logic [63:0] thr;
        logic [63:0] len;
        int unsigned pick;
        case ($urandom_range(5, 0))
            0: m = 64'($urandom_range(1000, 2));
            1: m = 64'd1 << $urandom_range(63, 1);
            2: m = {$urandom, $urandom} >> $urandom_range(63, 1);
            3: m = MOD_MAX;
            4: m = {$urandom, $urandom};
            default: m = 64'($urandom_range(1, 0));
        endcase
        bits = ($urandom_range(9, 0) == 0) ? 64'd0 : 64'($urandom_range(63, 1));
        m_eff = (m < MOD_MIN) ? MOD_MIN : ((m > MOD_MAX) ? MOD_MAX : m);
        span  = 64'd1 << bits;
        pick  = $urandom_range(9, 0);
        if (pick < 7)
            thr = (bits != 0 && m_eff <= span) ? span % m_eff : 64'd0;
        else if (pick < 9)
            thr = 64'd0;
        else
            thr = {$urandom, $urandom} >> $urandom_range(63, 0);
        pick = $urandom_range(19, 0);
        if (pick < 12)
            len = 64'($urandom_range(16, 1));
        else if (pick < 17)
            len = 64'($urandom_range(300, 17));
        else if (pick < 19)
            len = 64'($urandom_range(MAX_LEN, MAX_LEN - 1));
        else
            len = ($urandom_range(1, 0) == 0) ? 64'd0 : 64'($urandom_range(8191, MAX_LEN + 1));
        write_config(m, bits, thr, len);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        t_item       beat;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        for (int seg = 0; seg < 3; seg++) begin
            // Keep the store across settings, so stale entries and short passes show up.
            randomize_config();
            for (int k = 0; k < n_items / 3; k++) begin
                pick = $urandom_range(99, 0);
                if (pick < 2)       beat.opcode = OP_CLEAR;
                else if (pick < 27) beat.opcode = OP_READ;
                else if (pick < 60) beat.opcode = OP_SUB;
                else                beat.opcode = OP_ADD;
                pick = $urandom_range(19, 0);
                if (pick < 16)
                    beat.sample_word = {$urandom, $urandom};
                else if (pick < 17)
                    beat.sample_word = ALL_ONES;
                else
                    // Land on either side of the rejection threshold.
                    beat.sample_word = {1'b0, cfg_reject} - 64'd1 + 64'($urandom_range(2, 0));
                if ($urandom_range(9, 0) < 7)
                    beat.read_index = 12'($urandom_range(clamp_length() - 1, 0));
                else
                    beat.read_index = 12'($urandom);
                send_beat(beat);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial begin
        sender_idle_pct = 0;
        shadow_pos      = 0;
        cfg_modulus     = MOD_MIN;
        cfg_bits        = 6'd1;
        cfg_reject      = '0;
        cfg_length      = 13'd1;
        for (int i = 0; i < MAX_LEN; i++) shadow_store[i] = '0;
        rst_n   = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        // Hold off until the power-on sweep of the store is done.
        wait_idle();

        test_power_on_defaults();
        test_full_width();
        test_rejection();
        test_register_clamps();
        test_shrink_and_stale();

        test_random_traffic(37, 300);
        test_random_traffic(83, 300);
        test_random_traffic(0, 300);

        // Drain, then give a stray result time to show up.
        wait_idle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_modular_mask_accumulator_top: clean");
        else
            $display("tb_modular_mask_accumulator_top: errors");
        $finish;
    end

endmodule

/* files.f */
design/mma_pkg.sv
design/mma_store.sv
design/mma_rem.sv
design/modular_mask_accumulator_top.sv
design/mma_checker.sv
verif/tb_modular_mask_accumulator_top.sv
